// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the packet parser RTL. The checks
// are compiled in simulation and left empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition must hold at every clock edge outside reset.
`define APP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define APP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define APP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define APP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define APP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/app_pp_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet parser package
// Types, protocol constants and result record layout shared by the parser
// core, the result queue and the top level.
// ----------------------------------------------------------------------------
package app_pp_pkg;

    // Protocol bytes and header layout.
    localparam logic [7:0]  TypeData = 8'h01;
    localparam logic [7:0]  TagSize  = 8'h00;
    localparam logic [7:0]  TagName  = 8'h01;
    localparam logic [7:0]  SizeLen  = 8'd4;
    localparam logic [15:0] CtrlMin  = 16'd9;
    localparam logic [15:0] DataHdr  = 16'd3;
    localparam logic [14:0] PosMax   = 15'd32767;

    // Result queue depth; must be a power of two and at least two.
    localparam int unsigned ResDepth = 4;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_NAME    = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // Status error codes.
    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_SHORT       = 3'd1,
        ERR_SIZE_TAG    = 3'd2,
        ERR_SIZE_LEN    = 3'd3,
        ERR_NAME_TAG    = 3'd4,
        ERR_NAME_LEN    = 3'd5,
        ERR_TRUNCATED   = 3'd6,
        ERR_UNUSED      = 3'd7
    } t_err;

    // One result record as it travels through the result queue.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [7:0]  packet_type;
        logic [31:0] file_size;
        logic [14:0] payload_length;
        logic [7:0]  name_length;
        t_err        error_code;
        logic        last_of_step;
    } t_result;

endpackage

// ===== rtl/core/app_pp_parser.sv =====
// ----------------------------------------------------------------------------
// Packet parser core
// Holds the per-packet parse state and turns one registered packet byte into
// up to two result records (a payload or name byte, then the status record).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module app_pp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_eop,
    output logic [1:0]          o_push_cnt,
    output app_pp_pkg::t_result o_res_a,
    output app_pp_pkg::t_result o_res_b
);

    logic [14:0]      r_pos, n_pos;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_high, n_high;
    logic [14:0]      r_exp, n_exp;
    logic [31:0]      r_size, n_size;
    logic [7:0]       r_name, n_name;
    app_pp_pkg::t_err r_err, n_err;

    logic [15:0]         pos16;
    logic [15:0]         len;
    logic                is_data;
    logic                emit;
    app_pp_pkg::t_kind   emit_kind;
    app_pp_pkg::t_err    stat_err;
    app_pp_pkg::t_result res_byte;
    app_pp_pkg::t_result res_stat;
    logic [1:0]          cnt;

    assign pos16 = {1'b0, r_pos};
    assign len   = pos16 + 16'd1;

    // Field extraction and header checks for the current byte.
    always_comb begin
        n_pos     = (r_pos == app_pp_pkg::PosMax) ? r_pos : r_pos + 15'd1;
        n_type    = (r_pos == 15'd0) ? i_byte : r_type;
        n_high    = r_high;
        n_exp     = r_exp;
        n_size    = r_size;
        n_name    = r_name;
        n_err     = r_err;
        emit      = 1'b0;
        emit_kind = app_pp_pkg::KIND_PAYLOAD;
        is_data   = (n_type == app_pp_pkg::TypeData);

        if (is_data) begin
            if (r_pos == 15'd1) begin
                n_high = i_byte;
            end else if (r_pos == 15'd2) begin
                n_exp = {1'b0, r_high, 6'b0} + {7'b0, i_byte};
            end else if (pos16 >= app_pp_pkg::DataHdr &&
                         pos16 < ({1'b0, r_exp} + app_pp_pkg::DataHdr)) begin
                emit      = 1'b1;
                emit_kind = app_pp_pkg::KIND_PAYLOAD;
            end
        end else begin
            if (r_pos == 15'd1) begin
                if (i_byte != app_pp_pkg::TagSize && r_err == app_pp_pkg::ERR_OK) begin
                    n_err = app_pp_pkg::ERR_SIZE_TAG;
                end
            end else if (r_pos == 15'd2) begin
                if (i_byte != app_pp_pkg::SizeLen && r_err == app_pp_pkg::ERR_OK) begin
                    n_err = app_pp_pkg::ERR_SIZE_LEN;
                end
            end else if (r_pos >= 15'd3 && r_pos <= 15'd6) begin
                n_size = {r_size[23:0], i_byte};
            end else if (r_pos == 15'd7) begin
                if (i_byte != app_pp_pkg::TagName && r_err == app_pp_pkg::ERR_OK) begin
                    n_err = app_pp_pkg::ERR_NAME_TAG;
                end
            end else if (r_pos == 15'd8) begin
                n_name = i_byte;
                if (i_byte == 8'd0 && r_err == app_pp_pkg::ERR_OK) begin
                    n_err = app_pp_pkg::ERR_NAME_LEN;
                end
            end else if (pos16 >= app_pp_pkg::CtrlMin && r_err == app_pp_pkg::ERR_OK &&
                         pos16 < ({8'b0, r_name} + app_pp_pkg::CtrlMin)) begin
                emit      = 1'b1;
                emit_kind = app_pp_pkg::KIND_NAME;
            end
        end
    end

    // Status error code from the state as it stands after this byte.
    always_comb begin
        if (is_data) begin
            if (len <= app_pp_pkg::DataHdr) begin
                stat_err = app_pp_pkg::ERR_SHORT;
            end else if (({1'b0, n_exp} + app_pp_pkg::DataHdr) > len) begin
                stat_err = app_pp_pkg::ERR_TRUNCATED;
            end else begin
                stat_err = app_pp_pkg::ERR_OK;
            end
        end else begin
            if (len < app_pp_pkg::CtrlMin) begin
                stat_err = app_pp_pkg::ERR_SHORT;
            end else if (n_err != app_pp_pkg::ERR_OK) begin
                stat_err = n_err;
            end else if (({8'b0, n_name} + app_pp_pkg::CtrlMin) > len) begin
                stat_err = app_pp_pkg::ERR_TRUNCATED;
            end else begin
                stat_err = app_pp_pkg::ERR_OK;
            end
        end
    end

    // Build the two candidate records and pack them in output order.
    always_comb begin
        res_byte                = '0;
        res_byte.kind           = emit_kind;
        res_byte.out_byte       = i_byte;
        res_byte.error_code     = app_pp_pkg::ERR_OK;
        res_byte.last_of_step   = !i_eop;

        res_stat                = '0;
        res_stat.kind           = app_pp_pkg::KIND_STATUS;
        res_stat.packet_type    = n_type;
        res_stat.file_size      = is_data ? 32'd0 : n_size;
        res_stat.payload_length = is_data ? n_exp : 15'd0;
        res_stat.name_length    = is_data ? 8'd0 : n_name;
        res_stat.error_code     = stat_err;
        res_stat.last_of_step   = 1'b1;

        if (emit) begin
            o_res_a = res_byte;
            o_res_b = res_stat;
            cnt     = i_eop ? 2'd2 : 2'd1;
        end else begin
            o_res_a = res_stat;
            o_res_b = res_stat;
            cnt     = i_eop ? 2'd1 : 2'd0;
        end
    end

    assign o_push_cnt = i_step ? cnt : 2'd0;

    // Parse state; everything returns to zero once a packet ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_type <= '0;
            r_high <= '0;
            r_exp  <= '0;
            r_size <= '0;
            r_name <= '0;
            r_err  <= app_pp_pkg::ERR_OK;
        end else if (i_step) begin
            if (i_eop) begin
                r_pos  <= '0;
                r_type <= '0;
                r_high <= '0;
                r_exp  <= '0;
                r_size <= '0;
                r_name <= '0;
                r_err  <= app_pp_pkg::ERR_OK;
            end else begin
                r_pos  <= n_pos;
                r_type <= n_type;
                r_high <= n_high;
                r_exp  <= n_exp;
                r_size <= n_size;
                r_name <= n_name;
                r_err  <= n_err;
            end
        end
    end

    // A pair of records is always a data or name byte followed by the status.
    `APP_ASSERT_IMPLY(a_pair_order, i_clk, i_rst_n, o_push_cnt == 2'd2,
        o_res_a.kind != app_pp_pkg::KIND_STATUS && o_res_b.kind == app_pp_pkg::KIND_STATUS,
        "parser: result pair out of order")

    // The end of a packet restarts the byte count.
    `APP_ASSERT_NEXT(a_eop_restart, i_clk, i_rst_n, i_step && i_eop, r_pos == 15'd0,
        "parser: byte position not cleared after packet end")

endmodule

// ===== rtl/core/app_pp_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small queue of result records that takes zero, one or two records per cycle
// and hands out one per cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module app_pp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  app_pp_pkg::t_result i_push_a,
    input  app_pp_pkg::t_result i_push_b,
    output logic                o_space2,
    output logic                o_valid,
    output app_pp_pkg::t_result o_data,
    input  logic                i_ready
);

    localparam int unsigned Depth = app_pp_pkg::ResDepth;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    app_pp_pkg::t_result r_mem [Depth];
    logic [PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]     r_count, n_count;
    logic                pop;
    logic [PtrW-1:0]     wr_ptr_b;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_space2 = (r_count <= CntW'(Depth - 2));
    assign pop      = o_valid && i_ready;
    assign wr_ptr_b = r_wr_ptr + PtrW'(1);

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrW'(i_push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + PtrW'(1) : r_rd_ptr;
        n_count  = r_count + CntW'(i_push_cnt) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Record storage; the second record lands one slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push_b;
        end
    end

    // Occupancy never passes the depth.
    `APP_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, r_count <= CntW'(Depth),
        "result queue: overflow")

    // A pop without a push takes exactly one record away.
    `APP_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop && i_push_cnt == 2'd0,
        r_count == $past(r_count) - CntW'(1), "result queue: bad count after pop")

endmodule

// ===== rtl/core/app_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Packet parser unit
// Parses file-transfer packets one byte per word and reports payload bytes,
// file name bytes and a status record at each packet end.
// ----------------------------------------------------------------------------
// One packet byte is accepted per cycle. Each byte is registered, parsed
// once the queue has room for its results and yields zero, one or two result
// words (a payload or file name byte, then the status word on the
// end-of-packet byte), which are written into a four-entry result queue and
// presented at the output from its registered storage. The input stalls only
// while a byte is held and the queue has fewer than two free entries, so with
// a ready consumer the unit sustains one byte per cycle, and the queue drain
// of one word per cycle sets the rate when a packet ends.
// Payload and name bytes leave before the packet is checked: drop them when
// the status word reports a nonzero error code.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module app_packet_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Packet byte channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_packet_type,
    output logic [31:0] o_file_size,
    output logic [14:0] o_payload_length,
    output logic [7:0]  o_name_length,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_step
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eop;
    logic                step;
    logic                space2;
    logic [1:0]          push_cnt;
    app_pp_pkg::t_result res_a;
    app_pp_pkg::t_result res_b;
    app_pp_pkg::t_result out_res;

    // A held byte is parsed once the queue can take both of its results.
    assign step       = r_in_valid && space2;
    assign o_in_ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eop  <= i_end_of_packet;
        end
    end

    app_pp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_eop      (r_in_eop),
        .o_push_cnt (push_cnt),
        .o_res_a    (res_a),
        .o_res_b    (res_b)
    );

    app_pp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push_a   (res_a),
        .i_push_b   (res_b),
        .o_space2   (space2),
        .o_valid    (o_out_valid),
        .o_data     (out_res),
        .i_ready    (i_out_ready)
    );

    // Result word fields.
    assign o_kind           = out_res.kind;
    assign o_out_byte       = out_res.out_byte;
    assign o_packet_type    = out_res.packet_type;
    assign o_file_size      = out_res.file_size;
    assign o_payload_length = out_res.payload_length;
    assign o_name_length    = out_res.name_length;
    assign o_error_code     = out_res.error_code;
    assign o_last_of_step   = out_res.last_of_step;

    // A held byte that cannot be parsed keeps the input stalled.
    `APP_ASSERT_IMPLY(a_hold_stalls, i_clk, i_rst_n, r_in_valid && !space2, !o_in_ready,
        "unit: input taken while a byte is held")

endmodule
